@@ design/fibc_pkg.sv @@
// ----------------------------------------------------------------------------
// fibc_pkg
// Shared types and constants of the flux interval bit classifier: symbol
// codes, mode and register codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package fibc_pkg;

   localparam int COUNT_W  = 8;
   localparam int CT_W     = 9;
   localparam int SYM_W    = 2;
   localparam int MODE_W   = 2;
   localparam int FREQ_W   = 11;
   localparam int SHORT_W  = 8;
   localparam int LONG_W   = 9;
   localparam int ADV_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam int TAIL_LEN   = 5;
   localparam int TAIL_W     = TAIL_LEN * SYM_W;
   localparam int TAIL_CNT_W = 3;
   localparam int ZRUN_W     = 6;
   localparam int MAX_ZERO_RUN = 47;

   localparam int DVD_W    = 15;
   localparam int DSR_W    = 11;
   localparam int DCNT_W   = 4;
   localparam int DIV_STEPS = 15;

   // result symbol codes
   localparam logic [SYM_W-1:0] SYM_ZERO = 2'd0;
   localparam logic [SYM_W-1:0] SYM_ONE  = 2'd1;
   localparam logic [SYM_W-1:0] SYM_MARK = 2'd2;

   // decode modes; the fourth code decodes as dynamic
   localparam logic [MODE_W-1:0] MODE_FIXED   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TIMED   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DYNAMIC = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_FACTOR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_PERIOD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PERIOD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMING_ADVANCE = 3'd4;

   // register reset values
   localparam logic [MODE_W-1:0]  RST_DECODE_MODE    = MODE_DYNAMIC;
   localparam logic [FREQ_W-1:0]  RST_FREQ_FACTOR    = 11'd1000;
   localparam logic [SHORT_W-1:0] RST_SHORT_PERIOD   = 8'd22;
   localparam logic [LONG_W-1:0]  RST_LONG_PERIOD    = 9'd42;
   localparam logic [ADV_W-1:0]   RST_TIMING_ADVANCE = 4'd0;

   typedef struct packed {
      logic [MODE_W-1:0]  decode_mode;
      logic [FREQ_W-1:0]  freq_factor;
      logic [SHORT_W-1:0] short_period;
      logic [LONG_W-1:0]  long_period;
      logic [ADV_W-1:0]   timing_advance;
   } fibc_cfg_type;

   typedef struct packed {
      logic load;
      logic classify;
      logic div_step;
      logic zload;
      logic emit;
   } fibc_cmd_type;

   typedef struct packed {
      logic overlong;
      logic has_output;
      logic div_done;
      logic out_free;
      logic last_sym;
   } fibc_status_type;

endpackage

@@ design/fibc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fibc_ctrl
// Sequencer of the classifier: takes one request, classifies it, runs the
// divider for overlong spans and then emits symbols as the output frees up.
// ----------------------------------------------------------------------------
module fibc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  fibc_pkg::fibc_status_type status,
   output fibc_pkg::fibc_cmd_type    cmd
);
   import fibc_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CLASS = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            cmd.classify = 1'b1;
            if (status.overlong) begin
               state_in = S_DIV;
            end else if (status.has_output) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.zload = 1'b1;
               state_in  = S_EMIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               // drop back to idle once the final symbol is in the output register
               if (status.last_sym) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/fibc_datapath.sv @@
// ----------------------------------------------------------------------------
// fibc_datapath
// Interval sum, threshold compare, restoring divider for the overlong zero
// run, symbol sequencer and output register.
// ----------------------------------------------------------------------------
module fibc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  fibc_pkg::fibc_cfg_type          cfg,
   input  fibc_pkg::fibc_cmd_type          cmd,
   output fibc_pkg::fibc_status_type       status,
   input  logic [fibc_pkg::COUNT_W-1:0]    req_first_count,
   input  logic [fibc_pkg::COUNT_W-1:0]    req_second_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fibc_pkg::SYM_W-1:0]      rsp_symbol,
   output logic                            rsp_last
);
   import fibc_pkg::*;

   // symbol tails, first symbol in the low bits
   localparam logic [TAIL_W-1:0] TAIL_MARK     = {8'd0, SYM_MARK};
   localparam logic [TAIL_W-1:0] TAIL_MARK_ONE = {6'd0, SYM_ONE, SYM_MARK};
   localparam logic [TAIL_W-1:0] TAIL_ONE      = {8'd0, SYM_ONE};
   localparam logic [TAIL_W-1:0] TAIL_01       = {6'd0, SYM_ONE, SYM_ZERO};
   localparam logic [TAIL_W-1:0] TAIL_001      = {4'd0, SYM_ONE, SYM_ZERO, SYM_ZERO};
   localparam logic [TAIL_W-1:0] TAIL_LONG     =
      {SYM_MARK, SYM_ONE, SYM_ZERO, SYM_ZERO, SYM_ZERO};

   // config-derived thresholds, refreshed every cycle
   logic [17:0] t5_ff, t8_ff, t30_ff, t47_ff, t80_ff;
   logic [11:0] d_mark_ff;
   logic [15:0] d_one_ff, d_two_ff;
   logic [9:0]  d_three_ff;
   logic [12:0] p1_adv;
   logic [15:0] p2_x10;

   logic [CT_W-1:0] ct_ff;

   logic [TAIL_W-1:0]     tail_ff, tail_in;
   logic [TAIL_CNT_W-1:0] tlen_ff, tlen_in;
   logic [ZRUN_W-1:0]     zrun_ff, zrun_in;
   logic                  long_c;

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DSR_W-1:0]  dsr_ff, dsr_in;
   logic [DSR_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [DSR_W:0]    trial;

   logic [19:0] k_timed;
   logic [15:0] k_dyn;
   logic [ZRUN_W-1:0] zrun_q;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]  rsp_symbol_ff, rsp_symbol_in;
   logic              rsp_last_ff, rsp_last_in;

   assign p1_adv = 13'(cfg.short_period) * (13'd10 + 13'(cfg.timing_advance));
   assign p2_x10 = 16'(cfg.long_period) * 16'd10;

   always_ff @(posedge clock) begin
      t5_ff      <= 18'(cfg.freq_factor) * 18'd5;
      t8_ff      <= 18'(cfg.freq_factor) * 18'd8;
      t30_ff     <= 18'(cfg.freq_factor) * 18'd30;
      t47_ff     <= 18'(cfg.freq_factor) * 18'd47;
      t80_ff     <= 18'(cfg.freq_factor) * 18'd80;
      d_mark_ff  <= 12'(cfg.short_period) * (12'd15 - 12'(cfg.timing_advance));
      d_one_ff   <= p2_x10 + 16'(p1_adv);
      d_two_ff   <= {p2_x10[14:0], 1'b0} + 16'(p1_adv);
      d_three_ff <= 10'(cfg.long_period) + {1'b0, cfg.short_period, 1'b0};
   end

   assign k_timed = 20'(ct_ff) * 20'd1000;
   assign k_dyn   = 16'(ct_ff) * 16'd20;

   // classification
   always_comb begin
      tail_in = '0;
      tlen_in = '0;
      long_c  = 1'b0;
      unique case (cfg.decode_mode)
         MODE_FIXED: begin
            if (ct_ff >= 9'd7 && ct_ff <= 9'd12) begin
               tail_in = TAIL_MARK;     tlen_in = 3'd1;
            end else if (ct_ff >= 9'd13 && ct_ff <= 9'd14) begin
               tail_in = TAIL_MARK_ONE; tlen_in = 3'd2;
            end else if (ct_ff >= 9'd15 && ct_ff <= 9'd26) begin
               tail_in = TAIL_ONE;      tlen_in = 3'd1;
            end else if (ct_ff >= 9'd30 && ct_ff <= 9'd42) begin
               tail_in = TAIL_01;       tlen_in = 3'd2;
            end else if (ct_ff >= 9'd47 && ct_ff <= 9'd55) begin
               tail_in = TAIL_001;      tlen_in = 3'd3;
            end else if (ct_ff > 9'd55) begin
               tail_in = TAIL_MARK;     tlen_in = 3'd1;
            end
         end
         MODE_TIMED: begin
            if (k_timed < 20'(t5_ff)) begin
               tlen_in = 3'd0;
            end else if (k_timed < 20'(t8_ff)) begin
               tail_in = TAIL_MARK;     tlen_in = 3'd1;
            end else if (k_timed < 20'(t30_ff)) begin
               tail_in = TAIL_ONE;      tlen_in = 3'd1;
            end else if (k_timed < 20'(t47_ff)) begin
               tail_in = TAIL_01;       tlen_in = 3'd2;
            end else if (k_timed <= 20'(t80_ff)) begin
               tail_in = TAIL_001;      tlen_in = 3'd3;
            end else begin
               tail_in = TAIL_LONG;     tlen_in = 3'd5; long_c = 1'b1;
            end
         end
         default: begin
            if ({ct_ff, 1'b0} < 10'(cfg.short_period)) begin
               tlen_in = 3'd0;
            end else if (k_dyn < 16'(d_mark_ff)) begin
               tail_in = TAIL_MARK;     tlen_in = 3'd1;
            end else if (k_dyn < d_one_ff) begin
               tail_in = TAIL_ONE;      tlen_in = 3'd1;
            end else if (k_dyn < d_two_ff) begin
               tail_in = TAIL_01;       tlen_in = 3'd2;
            end else if (10'(ct_ff) < d_three_ff) begin
               tail_in = TAIL_001;      tlen_in = 3'd3;
            end else begin
               tail_in = TAIL_LONG;     tlen_in = 3'd5; long_c = 1'b1;
            end
         end
      endcase
   end

   // restoring divider, one quotient bit a cycle; a zero divisor gives all ones
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.classify) begin
         rem_in  = '0;
         dcnt_in = DCNT_W'(DIV_STEPS);
         if (cfg.decode_mode == MODE_TIMED) begin
            dvd_in = DVD_W'(ct_ff) * DVD_W'(50);
            dsr_in = cfg.freq_factor;
         end else begin
            dvd_in = DVD_W'(ct_ff);
            dsr_in = DSR_W'(cfg.short_period);
         end
      end else if (cmd.div_step) begin
         dcnt_in = dcnt_ff - 1'b1;
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DSR_W'(trial - {1'b0, dsr_ff});
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DSR_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
      end
   end

   // zero run: quotient less four, clamped to 0..MAX_ZERO_RUN (47)
   always_comb begin
      if (dvd_ff < DVD_W'(4)) begin
         zrun_q = '0;
      end else if (dvd_ff >= DVD_W'(MAX_ZERO_RUN + 4)) begin
         zrun_q = ZRUN_W'(MAX_ZERO_RUN);
      end else begin
         zrun_q = ZRUN_W'(dvd_ff - DVD_W'(4));
      end
   end

   // symbol sequencer and output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      zrun_in       = zrun_ff;
      if (cmd.classify) begin
         zrun_in = '0;
      end else if (cmd.zload) begin
         zrun_in = zrun_q;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = status.last_sym;
         if (zrun_ff != '0) begin
            rsp_symbol_in = SYM_ZERO;
            zrun_in       = zrun_ff - 1'b1;
         end else begin
            rsp_symbol_in = tail_ff[SYM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ct_ff <= CT_W'(req_first_count) + CT_W'(req_second_count);
      end
      if (cmd.classify) begin
         tail_ff <= tail_in;
         tlen_ff <= tlen_in;
      end else if (cmd.emit && zrun_ff == '0) begin
         // advance the tail
         tail_ff <= {{SYM_W{1'b0}}, tail_ff[TAIL_W-1:SYM_W]};
         tlen_ff <= tlen_ff - 1'b1;
      end
      zrun_ff       <= zrun_in;
      dvd_ff        <= dvd_in;
      dsr_ff        <= dsr_in;
      rem_ff        <= rem_in;
      dcnt_ff       <= dcnt_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.overlong   = long_c;
   assign status.has_output = (tlen_in != '0);
   assign status.div_done   = (dcnt_ff == '0);
   assign status.out_free   = ~rsp_valid_ff | rsp_ready;
   assign status.last_sym   = (zrun_ff == '0) && (tlen_ff == TAIL_CNT_W'(1));

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ design/flux_interval_bit_classifier.sv @@
// Sequence: an accepted request is summed and classified, then its symbols are
//   emitted; an overlong span first runs the restoring divider for the zero run.
// Throughput: one symbol per cycle while the output is not stalled.
//   No overlap of requests: a new one is taken only when the last is done.
// Reset: registers return to dynamic mode defaults, sequencer idle, output empty.
// ----------------------------------------------------------------------------
// flux_interval_bit_classifier
// Sums two run-length counts of a flux span and classifies the interval into
// disk bit symbols in fixed, timed or dynamic threshold mode.
// ----------------------------------------------------------------------------
module flux_interval_bit_classifier (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fibc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fibc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fibc_pkg::COUNT_W-1:0]     req_first_count,
   input  logic [fibc_pkg::COUNT_W-1:0]     req_second_count,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fibc_pkg::SYM_W-1:0]       rsp_symbol,
   output logic                             rsp_last
);
   import fibc_pkg::*;

   fibc_cfg_type    cfg_ff;
   fibc_cfg_type    cfg_in;
   fibc_cmd_type    cmd;
   fibc_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DECODE_MODE:    cfg_in.decode_mode    = csr_data[MODE_W-1:0];
            CSR_FREQ_FACTOR:    cfg_in.freq_factor    = csr_data[FREQ_W-1:0];
            CSR_SHORT_PERIOD:   cfg_in.short_period   = csr_data[SHORT_W-1:0];
            CSR_LONG_PERIOD:    cfg_in.long_period    = csr_data[LONG_W-1:0];
            CSR_TIMING_ADVANCE: cfg_in.timing_advance = csr_data[ADV_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decode_mode    <= RST_DECODE_MODE;
         cfg_ff.freq_factor    <= RST_FREQ_FACTOR;
         cfg_ff.short_period   <= RST_SHORT_PERIOD;
         cfg_ff.long_period    <= RST_LONG_PERIOD;
         cfg_ff.timing_advance <= RST_TIMING_ADVANCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fibc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fibc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .status           (status),
      .req_first_count  (req_first_count),
      .req_second_count (req_second_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_last         (rsp_last)
   );

endmodule
